[rtl/core/cycle_time_monitor_top_defines.svh]
// Assertion macros used by the cycle time monitor checker.
`ifndef CYCLE_TIME_MONITOR_TOP_DEFINES_SVH
`define CYCLE_TIME_MONITOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CTM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CTM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ctm_pkg.sv]
// Types and constants of the cycle time monitor.
`default_nettype none
package ctm_pkg;

    localparam logic [31:0] MAX_INTERVAL_US   = 32'd3600000000;
    localparam logic [26:0] MAX_THRESHOLD_US  = 27'd99999000;
    localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_INTERVAL_US   = 32'd5000000;
    localparam logic [26:0] RST_THR_LOW_US    = 27'd30;
    localparam logic [26:0] RST_THR_HIGH_US   = 27'd120;
    localparam int          HITS_OUT_W        = 14;

    typedef enum logic [1:0] {
        REQ_LOOP  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_THR_LOW  = 2'd1,
        CFG_THR_HIGH = 2'd2
    } cfg_idx_t;

    // effective (saturated) configuration
    typedef struct packed {
        logic [31:0] interval;
        logic [31:0] limit;
        logic [26:0] thr_high;
        logic [26:0] thr_low;
    } ctm_cfg_t;

    typedef struct packed {
        logic                  section_mode;
        logic [HITS_OUT_W-1:0] over_high_count;
        logic [HITS_OUT_W-1:0] over_low_count;
        logic [31:0]           max_time_us;
        logic [31:0]           total_time_us;
        logic [31:0]           event_count;
    } ctm_result_t;

endpackage
`default_nettype wire

[rtl/core/ctm_cfg.sv]
// Configuration registers and registered effective limits.
`default_nettype none
module ctm_cfg #(
    parameter int WRAP_GUARD = 10
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [31:0]      cfg_wdata,
    output ctm_pkg::ctm_cfg_t     cfg_eff
);
    import ctm_pkg::*;

    localparam logic [31:0] GUARD = 32'(WRAP_GUARD);

    logic [31:0] interval_reg;
    logic [26:0] thr_low_reg;
    logic [26:0] thr_high_reg;
    ctm_cfg_t    eff_reg;
    ctm_cfg_t    eff_next;
    ctm_cfg_t    eff_rst;

    always_comb begin
        eff_next.interval = (interval_reg > MAX_INTERVAL_US) ? MAX_INTERVAL_US : interval_reg;
        eff_next.limit    = COUNT_MAX - eff_next.interval - GUARD;
        eff_next.thr_high = (thr_high_reg > MAX_THRESHOLD_US) ? MAX_THRESHOLD_US
                                                                : thr_high_reg;
        eff_next.thr_low  = (thr_low_reg < eff_next.thr_high) ? thr_low_reg
                                                                : eff_next.thr_high;
        eff_rst.interval  = RST_INTERVAL_US;
        eff_rst.limit     = COUNT_MAX - RST_INTERVAL_US - GUARD;
        eff_rst.thr_high  = RST_THR_HIGH_US;
        eff_rst.thr_low   = RST_THR_LOW_US;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= RST_INTERVAL_US;
            thr_low_reg  <= RST_THR_LOW_US;
            thr_high_reg <= RST_THR_HIGH_US;
            eff_reg      <= eff_rst;
        end else begin
            eff_reg <= eff_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_INTERVAL: interval_reg <= cfg_wdata;
                    CFG_THR_LOW:  thr_low_reg  <= cfg_wdata[26:0];
                    CFG_THR_HIGH: thr_high_reg <= cfg_wdata[26:0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg_eff = eff_reg;

endmodule
`default_nettype wire

[rtl/core/ctm_engine.sv]
// Input register, monitor state and single-pass event update.
`default_nettype none
module ctm_engine #(
    parameter int HIT_LIMIT = 9999
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,
    input  wire logic [1:0]        s_tuser,
    input  wire ctm_pkg::ctm_cfg_t cfg_eff,
    input  wire logic              out_free,
    output logic                   res_valid,
    output ctm_pkg::ctm_result_t   res
);
    import ctm_pkg::*;

    localparam int HIT_W = $clog2(HIT_LIMIT + 1);
    localparam logic [HIT_W-1:0] HIT_MAX = HIT_W'(HIT_LIMIT);

    logic              in_valid_reg;
    logic [1:0]        in_kind_reg;
    logic [31:0]       in_ts_reg;
    logic              process;

    logic              active_reg,     active_next;
    logic              mark_valid_reg, mark_valid_next;
    logic [31:0]       last_mark_reg,  last_mark_next;
    logic [31:0]       max_reg,        max_next;
    logic [HIT_W-1:0]  low_hits_reg,   low_hits_next;
    logic [HIT_W-1:0]  high_hits_reg,  high_hits_next;
    logic [31:0]       loop_cnt_reg,   loop_cnt_next;
    logic [31:0]       loop_tot_reg,   loop_tot_next;
    logic              sec_flag_reg,   sec_flag_next;
    logic [31:0]       sec_start_reg,  sec_start_next;
    logic [31:0]       sec_cnt_reg,    sec_cnt_next;
    logic [31:0]       sec_tot_reg,    sec_tot_next;

    logic [31:0]       dur;
    logic              judge_en;
    logic              report;
    logic [31:0]       loop_cnt_inc;

    assign process  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign dur          = in_ts_reg - ((in_kind_reg == REQ_STOP) ? sec_start_reg : last_mark_reg);
    assign loop_cnt_inc = (loop_cnt_reg == COUNT_MAX) ? loop_cnt_reg : loop_cnt_reg + 32'd1;

    always_comb begin
        active_next     = active_reg;
        mark_valid_next = mark_valid_reg;
        last_mark_next  = last_mark_reg;
        max_next        = max_reg;
        low_hits_next   = low_hits_reg;
        high_hits_next  = high_hits_reg;
        loop_cnt_next   = loop_cnt_reg;
        loop_tot_next   = loop_tot_reg;
        sec_flag_next   = sec_flag_reg;
        sec_start_next  = sec_start_reg;
        sec_cnt_next    = sec_cnt_reg;
        sec_tot_next    = sec_tot_reg;
        judge_en        = 1'b0;
        report          = 1'b0;
        res             = '0;

        if (process) begin
            case (in_kind_reg)
                REQ_START: begin
                    sec_flag_next  = 1'b1;
                    sec_start_next = in_ts_reg;
                end
                REQ_STOP: begin
                    if (sec_cnt_reg != COUNT_MAX)
                        sec_cnt_next = sec_cnt_reg + 32'd1;
                    if (mark_valid_reg && active_reg && sec_flag_reg) begin
                        sec_tot_next = sec_tot_reg + dur;
                        judge_en     = 1'b1;
                    end
                end
                REQ_LOOP: begin
                    loop_cnt_next = loop_cnt_inc;
                    if (!active_reg) begin
                        if (in_ts_reg < cfg_eff.limit) begin
                            active_next     = 1'b1;
                            mark_valid_next = 1'b0;
                            last_mark_next  = '0;
                            max_next        = '0;
                            low_hits_next   = '0;
                            high_hits_next  = '0;
                            loop_cnt_next   = '0;
                            loop_tot_next   = '0;
                        end
                    end else begin
                        if (mark_valid_reg) begin
                            loop_tot_next = loop_tot_reg + dur;
                            judge_en      = !sec_flag_reg;
                        end
                        if (in_ts_reg > cfg_eff.limit) begin
                            active_next = 1'b0;
                        end else begin
                            last_mark_next  = in_ts_reg;
                            mark_valid_next = 1'b1;
                        end
                        report = (loop_tot_next > cfg_eff.interval);
                    end
                end
                default: ;
            endcase
        end

        if (judge_en) begin
            if (dur > max_reg)
                max_next = dur;
            if (dur > {5'd0, cfg_eff.thr_high}) begin
                if (high_hits_reg < HIT_MAX)
                    high_hits_next = high_hits_reg + HIT_W'(1);
            end else if (dur > {5'd0, cfg_eff.thr_low}) begin
                if (low_hits_reg < HIT_MAX)
                    low_hits_next = low_hits_reg + HIT_W'(1);
            end
        end

        if (report) begin
            res.event_count     = sec_flag_reg ? sec_cnt_next : loop_cnt_next;
            res.total_time_us   = sec_flag_reg ? sec_tot_next : loop_tot_next;
            res.max_time_us     = max_next;
            res.over_low_count  = HITS_OUT_W'(low_hits_next);
            res.over_high_count = HITS_OUT_W'(high_hits_next);
            res.section_mode    = sec_flag_reg;
            max_next            = '0;
            low_hits_next       = '0;
            high_hits_next      = '0;
            loop_cnt_next       = '0;
            loop_tot_next       = '0;
            sec_cnt_next        = '0;
            sec_tot_next        = '0;
        end
    end

    assign res_valid = report;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            active_reg     <= 1'b0;
            mark_valid_reg <= 1'b0;
            last_mark_reg  <= '0;
            max_reg        <= '0;
            low_hits_reg   <= '0;
            high_hits_reg  <= '0;
            loop_cnt_reg   <= '0;
            loop_tot_reg   <= '0;
            sec_flag_reg   <= 1'b0;
            sec_start_reg  <= '0;
            sec_cnt_reg    <= '0;
            sec_tot_reg    <= '0;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            active_reg     <= active_next;
            mark_valid_reg <= mark_valid_next;
            last_mark_reg  <= last_mark_next;
            max_reg        <= max_next;
            low_hits_reg   <= low_hits_next;
            high_hits_reg  <= high_hits_next;
            loop_cnt_reg   <= loop_cnt_next;
            loop_tot_reg   <= loop_tot_next;
            sec_flag_reg   <= sec_flag_next;
            sec_start_reg  <= sec_start_next;
            sec_cnt_reg    <= sec_cnt_next;
            sec_tot_reg    <= sec_tot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_ts_reg   <= s_tdata;
        end
    end

endmodule
`default_nettype wire

[rtl/core/cycle_time_monitor_top.sv]
// Top level of the cycle time monitor.
//
// Input stream: one transaction per timestamped event. s_tuser carries the
// event kind (loop mark, section start, section stop), s_tdata the 32-bit
// microsecond timestamp. Kind code 3 is dropped without effect.
// Output stream: one report transaction when the summed loop time passes
// the report interval on a loop mark; counters are cleared by that report.
// Config port: cfg_we/cfg_index/cfg_wdata write the interval and the two
// thresholds; write only while no event is in flight.
// Report path: an accepted loop mark is held in the input register; the update
// runs from there into the output register, which drives m_tvalid.
// Throughput: one event per cycle while the output register is free; the whole
// update is one subtract, adds and a few compares between those registers.
// Stall: a report held by a low m_tready blocks the event register, so
// s_tready drops after at most one more event is taken.
// Reset: synchronous, active low; all statistics cleared, monitor inactive
// until the first loop mark below the wrap limit, registers at defaults.
`default_nettype none
module cycle_time_monitor_top #(
    parameter int HIT_LIMIT  = 9999,
    parameter int WRAP_GUARD = 10
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] timestamp_us
    input  wire logic [1:0]   s_tuser,   // [1:0] req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] event_count, [63:32] total_time_us, [95:64] max_time_us,
    // [109:96] over_low_count, [123:110] over_high_count, [127:124] zero
    output logic [127:0]      m_tdata,
    output logic              m_tuser,   // [0] section_mode
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);
    import ctm_pkg::*;

    ctm_cfg_t    cfg_eff;
    logic        out_free;
    logic        res_valid;
    ctm_result_t res;
    logic        m_valid_reg;
    ctm_result_t m_res_reg;

    ctm_cfg #(
        .WRAP_GUARD (WRAP_GUARD)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_eff   (cfg_eff)
    );

    ctm_engine #(
        .HIT_LIMIT (HIT_LIMIT)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_eff   (cfg_eff),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid)
            m_res_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_res_reg.over_high_count, m_res_reg.over_low_count,
                       m_res_reg.max_time_us, m_res_reg.total_time_us,
                       m_res_reg.event_count};
    assign m_tuser  = m_res_reg.section_mode;

endmodule
`default_nettype wire

[rtl/core/ctm_checker.sv]
// Port-level checker for the cycle time monitor, bound to the top level.
`default_nettype none
`include "cycle_time_monitor_top_defines.svh"
module ctm_checker #(
    parameter int HIT_LIMIT = 9999
) (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic         m_tuser
);
    logic [14:0] hits_sum;
    assign hits_sum = {1'b0, m_tdata[109:96]} + {1'b0, m_tdata[123:110]};

    `CTM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "report changed while stalled")
    `CTM_ASSERT_NOW(a_hits_limit, aclk, aresetn, m_tvalid && (HIT_LIMIT < 16384), (m_tdata[109:96] <= HIT_LIMIT) && (m_tdata[123:110] <= HIT_LIMIT), "hit count above limit")
    `CTM_ASSERT_NOW(a_loop_total, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[63:32] != 32'd0, "loop report with zero total")
    `CTM_ASSERT_NOW(a_hits_le_count, aclk, aresetn, m_tvalid && !m_tuser, {17'd0, hits_sum} <= m_tdata[31:0], "more hits than loop marks")

endmodule

bind cycle_time_monitor_top ctm_checker #(
    .HIT_LIMIT (HIT_LIMIT)
) u_ctm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[test/cycle_time_monitor_top_test.sv]
`timescale 1ns / 1ps
// Self-checking stream testbench of the cycle time monitor: directed events mixed with random phases.
module cycle_time_monitor_top_test;
    import ctm_pkg::*;

    localparam int         HIT_LIMIT     = 9999;
    localparam int         WRAP_GUARD    = 10;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         PHASE_EVENTS  = 120;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         DIRECTED_ROWS = 22;
    localparam int         SECTION_ROW   = 10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ts;
        logic        typed;
        ctm_result_t rep;
    } stim_row_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    // monitor model state
    logic [31:0] cfg_interval     = RST_INTERVAL_US;
    logic [26:0] cfg_thr_low      = RST_THR_LOW_US;
    logic [26:0] cfg_thr_high     = RST_THR_HIGH_US;
    logic        mon_active       = 1'b0;
    logic        mark_held        = 1'b0;
    logic        in_sections      = 1'b0;
    logic [31:0] last_mark_ts     = '0;
    logic [31:0] peak_dur         = '0;
    logic [13:0] low_hits         = '0;
    logic [13:0] high_hits        = '0;
    logic [31:0] loop_marks       = '0;
    logic [31:0] loop_sum         = '0;
    logic [31:0] section_begin_ts = '0;
    logic [31:0] stop_count       = '0;
    logic [31:0] section_sum      = '0;

    ctm_result_t pending_reports[$];
    stim_row_t   directed_rows[DIRECTED_ROWS];
    logic [31:0] stim_now           = '0;
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          mismatch_count     = 0;
    int          cycle_count        = 0;

    cycle_time_monitor_top #(.HIT_LIMIT(HIT_LIMIT), .WRAP_GUARD(WRAP_GUARD)) dut (.*);

    always #1 aclk = ~aclk;

    function automatic logic [31:0] capped_interval();
        return (cfg_interval > MAX_INTERVAL_US) ? MAX_INTERVAL_US : cfg_interval;
    endfunction

    function automatic void clear_stats();
        peak_dur   = '0;
        low_hits   = '0;
        high_hits  = '0;
        loop_marks = '0;
        loop_sum   = '0;
    endfunction

    function automatic void grade_duration(input logic [31:0] dur);
        logic [31:0] hi;
        logic [31:0] lo;
        hi = (cfg_thr_high > MAX_THRESHOLD_US) ? 32'(MAX_THRESHOLD_US) : 32'(cfg_thr_high);
        lo = (32'(cfg_thr_low) < hi) ? 32'(cfg_thr_low) : hi;
        if (dur > peak_dur) begin
            peak_dur = dur;
        end
        if (dur > hi) begin
            if (high_hits < HIT_LIMIT) high_hits++;
        end else if (dur > lo) begin
            if (low_hits < HIT_LIMIT) low_hits++;
        end
    endfunction

    function automatic void advance_monitor(input logic [1:0] kind, input logic [31:0] ts,
                                            output bit fired, output ctm_result_t rep);
        logic [31:0] span;
        logic [31:0] wrap_limit;
        logic [31:0] dur;
        span       = capped_interval();
        wrap_limit = COUNT_MAX - span - 32'(WRAP_GUARD);
        fired      = 1'b0;
        rep        = '0;
        case (kind)
            REQ_START: begin
                in_sections      = 1'b1;
                section_begin_ts = ts;
            end
            REQ_STOP: begin
                if (stop_count != COUNT_MAX) stop_count++;
                if (mark_held && mon_active && in_sections) begin
                    dur         = ts - section_begin_ts;
                    section_sum = section_sum + dur;
                    grade_duration(dur);
                end
            end
            REQ_LOOP: begin
                if (loop_marks != COUNT_MAX) loop_marks++;
                if (!mon_active) begin
                    // re-arm below the wrap limit
                    if (ts < wrap_limit) begin
                        mon_active = 1'b1;
                        clear_stats();
                        mark_held    = 1'b0;
                        last_mark_ts = '0;
                    end
                end else begin
                    if (mark_held) begin
                        dur      = ts - last_mark_ts;
                        loop_sum = loop_sum + dur;
                        if (!in_sections) grade_duration(dur);
                    end
                    if (ts > wrap_limit) begin
                        mon_active = 1'b0;
                    end else begin
                        last_mark_ts = ts;
                        mark_held    = 1'b1;
                    end
                    if (loop_sum > span) begin
                        fired               = 1'b1;
                        rep.event_count     = in_sections ? stop_count : loop_marks;
                        rep.total_time_us   = in_sections ? section_sum : loop_sum;
                        rep.max_time_us     = peak_dur;
                        rep.over_low_count  = low_hits;
                        rep.over_high_count = high_hits;
                        rep.section_mode    = in_sections;
                        clear_stats();
                        stop_count  = '0;
                        section_sum = '0;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic stim_row_t plain_row(input logic [1:0] kind, input logic [31:0] ts);
        stim_row_t entry;
        entry      = '0;
        entry.kind = kind;
        entry.ts   = ts;
        return entry;
    endfunction

    function automatic stim_row_t report_row(input logic [1:0] kind, input logic [31:0] ts,
            input logic [31:0] n_events, total, peak, input logic [13:0] low, high);
        stim_row_t entry;
        entry                     = plain_row(kind, ts);
        entry.typed               = 1'b1;
        entry.rep.event_count     = n_events;
        entry.rep.total_time_us   = total;
        entry.rep.max_time_us     = peak;
        entry.rep.over_low_count  = low;
        entry.rep.over_high_count = high;
        return entry;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got, want);
        if (mismatch_count < 50) begin
            $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic post_event(input logic [1:0] kind, input logic [31:0] ts,
                              input bit typed = 1'b0, input ctm_result_t typed_rep = '0);
        bit          fired;
        ctm_result_t rep;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= ts;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_monitor(kind, ts, fired, rep);
        if (typed) begin
            pending_reports.push_back(typed_rep);
        end else if (fired) begin
            pending_reports.push_back(rep);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [31:0] interval, input logic [26:0] low, high);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INTERVAL;
        cfg_wdata <= interval;
        @(posedge aclk);
        // bits above the register width are dropped
        cfg_index <= CFG_THR_LOW;
        cfg_wdata <= {5'($urandom), low};
        @(posedge aclk);
        cfg_index <= CFG_THR_HIGH;
        cfg_wdata <= {5'($urandom), high};
        @(posedge aclk);
        cfg_we       <= 1'b0;
        cfg_interval = interval;
        cfg_thr_low  = low;
        cfg_thr_high = high;
    endtask

    task automatic run_rows(input int first, input int last);
        for (int i = first; i < last; i++) begin
            post_event(directed_rows[i].kind, directed_rows[i].ts, directed_rows[i].typed,
                       directed_rows[i].rep);
        end
    endtask

    task automatic run_phase(input logic [31:0] interval, input logic [26:0] low, high,
                             input int sender_pct, stall_pct, input bit with_sections);
        int          sent;
        int          roll;
        logic [1:0]  kind;
        logic [31:0] ts;
        logic [31:0] gap;
        wait_idle();
        configure(interval, low, high);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_EVENTS) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                kind = REQ_UNUSED;
                ts   = $urandom;
            end else if (roll < 10) begin
                if (with_sections) begin
                    kind = 2'($urandom_range(0, 2));
                end else begin
                    kind = $urandom_range(0, 1) ? REQ_STOP : REQ_LOOP;
                end
                ts = $urandom;
            end else if (roll < 13) begin
                // jump close to the timestamp wrap
                stim_now = COUNT_MAX - $urandom_range(0, capped_interval() + 40);
                kind     = REQ_LOOP;
                ts       = stim_now;
            end else begin
                roll = $urandom_range(0, 99);
                if (with_sections) begin
                    kind = (roll < 50) ? REQ_LOOP : (roll < 75) ? REQ_START : REQ_STOP;
                end else begin
                    kind = (roll < 85) ? REQ_LOOP : REQ_STOP;
                end
                case ($urandom_range(0, 9))
                    0, 1, 2: gap = 32'(cfg_thr_low) + $urandom_range(0, 4) - 32'd2;
                    3, 4, 5: gap = 32'(cfg_thr_high) + $urandom_range(0, 4) - 32'd2;
                    6:       gap = $urandom_range(0, 2 * 32'(cfg_thr_high) + 10);
                    7:       gap = $urandom_range(0, 64);
                    8:       gap = $urandom_range(0, capped_interval());
                    default: gap = $urandom;
                endcase
                stim_now = stim_now + gap;
                ts       = stim_now;
            end
            post_event(kind, ts);
            if (kind != REQ_UNUSED) sent++;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin : check_reports
        ctm_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("report with none pending", m_tdata[31:0], '0);
            end else begin
                want = pending_reports.pop_front();
                if (m_tdata[31:0] !== want.event_count)
                    flag_mismatch("event_count", m_tdata[31:0], want.event_count);
                if (m_tdata[63:32] !== want.total_time_us)
                    flag_mismatch("total_time_us", m_tdata[63:32], want.total_time_us);
                if (m_tdata[95:64] !== want.max_time_us)
                    flag_mismatch("max_time_us", m_tdata[95:64], want.max_time_us);
                if (m_tdata[109:96] !== want.over_low_count)
                    flag_mismatch("over_low_count", m_tdata[109:96], want.over_low_count);
                if (m_tdata[123:110] !== want.over_high_count)
                    flag_mismatch("over_high_count", m_tdata[123:110], want.over_high_count);
                if (m_tdata[127:124] !== 4'd0)
                    flag_mismatch("tdata padding", m_tdata[127:124], '0);
                if (m_tuser !== want.section_mode)
                    flag_mismatch("section_mode", m_tuser, want.section_mode);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        directed_rows = '{
            plain_row(REQ_LOOP, 32'hFFFF_FFFF),     // inactive, above the wrap limit
            plain_row(REQ_UNUSED, 32'd0),
            plain_row(REQ_LOOP, 32'd100),           // arms
            plain_row(REQ_LOOP, 32'd150),
            plain_row(REQ_LOOP, 32'd300),
            plain_row(REQ_LOOP, 32'd330),           // equal to low threshold
            plain_row(REQ_LOOP, 32'd450),           // equal to high threshold
            report_row(REQ_LOOP, 32'd5000451, 32'd5, 32'd5000301, 32'd5000001, 14'd1, 14'd2),
            report_row(REQ_LOOP, 32'hFFFF_FFFF, 32'd1, 32'd4289966844, 32'd4289966844,
                       14'd0, 14'd1),
            plain_row(REQ_LOOP, 32'd5),             // re-arm after wrap
            plain_row(REQ_LOOP, 32'hFFFF_FFFF),
            plain_row(REQ_LOOP, 32'd5),
            plain_row(REQ_STOP, 32'd20),            // stop before any start
            plain_row(REQ_START, 32'd30),
            plain_row(REQ_LOOP, 32'd40),
            plain_row(REQ_STOP, 32'd30),            // zero duration
            plain_row(REQ_STOP, 32'd29),            // duration wraps
            plain_row(REQ_START, 32'd1000),
            plain_row(REQ_STOP, 32'd1031),
            plain_row(REQ_STOP, 32'd1000),          // reuses old start
            plain_row(REQ_STOP, 32'd1151),
            plain_row(REQ_LOOP, 32'd5000100)
        };
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        run_rows(0, SECTION_ROW);
        run_phase(32'd1000, 27'd30, 27'd120, 0, 0, 1'b0);
        run_phase(32'd0, 27'd0, 27'd0, 65, 0, 1'b0);

        wait_idle();
        configure(RST_INTERVAL_US, RST_THR_LOW_US, RST_THR_HIGH_US);
        run_rows(SECTION_ROW, DIRECTED_ROWS);
        run_phase(32'd2000, 27'd50, 27'd40, 0, 65, 1'b1);
        run_phase(32'hFFFF_FFFF, MAX_THRESHOLD_US, 27'h7FF_FFFF, 30, 30, 1'b1);
        run_phase(32'd500, 27'h7FF_FFFF, 27'd100, 0, 0, 1'b1);
        run_phase(MAX_INTERVAL_US, MAX_THRESHOLD_US, MAX_THRESHOLD_US, 65, 0, 1'b1);
        run_phase(32'd800, 27'd30, 27'd120, 0, 65, 1'b1);
        run_phase(32'd1500, 27'd5, 27'd60, 30, 30, 1'b1);

        // run of section stops on both sides of the high threshold
        wait_idle();
        configure(32'hFFFF_FFFF, 27'd0, 27'd100);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        post_event(REQ_LOOP, 32'hFFFF_FFFF);
        post_event(REQ_LOOP, 32'd10);
        post_event(REQ_LOOP, 32'd20);
        post_event(REQ_START, 32'd1000);
        repeat (20) begin
            post_event(REQ_STOP, 32'd1050);
            post_event(REQ_STOP, 32'd1200);
        end
        post_event(REQ_LOOP, 32'hFFFF_FFF0);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
